[rtl/core/icalc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package icalc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int PERCENT_DIV    = 100;

    typedef enum logic [2:0] {
        K_ADD  = 3'd0,
        K_SUB  = 3'd1,
        K_MUL  = 3'd2,
        K_DIV  = 3'd3,
        K_POW  = 3'd4,
        K_SQRT = 3'd5,
        K_PCT  = 3'd6,
        K_FACT = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_NEGROOT = 2'd2,
        ST_OVF     = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DIV  = 6'b000100,
        S_ROOT = 6'b001000,
        S_LOOP = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

[rtl/core/integer_calculator_alu.sv]
// Add and sub pass through the finish state to the output register; mul, div, percent and sqrt
// first run their shift-add, restoring or digit-by-digit root loop. Power and factorial run one
// shift-add multiply per factor; at most about 2*DATA_WIDTH factors.
// Throughput: one word at a time; the next word enters once the previous one reaches the
// output register. Reset clears the sequencer and the output valid at once.
`timescale 1ns / 1ps
`default_nettype none

module integer_calculator_alu
    import icalc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          s_axis_tvalid,
    output logic                                         s_axis_tready,
    // operand_a, operand_b, zero pad
    input  wire  [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0]   s_axis_tdata,
    // kind
    input  wire  [2:0]                                   s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  wire                                          m_axis_tready,
    // value, status, zero pad
    output logic [((DATA_WIDTH + 2 + 7) / 8) * 8 - 1:0]   m_axis_tdata
);

    localparam int W     = DATA_WIDTH;
    localparam int OUT_W = ((W + 2 + 7) / 8) * 8;
    localparam int CW    = $clog2(W + 1);
    localparam int NP    = (W + 1) / 2;
    localparam int IW    = $clog2(2 * W) + 1;

    localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE      = W'(1);

    state_t          state_reg, state_next;
    kind_t           op_reg, op_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]    hi_reg, hi_next;
    logic [W-1:0]    lo_reg, lo_next;
    logic [W-1:0]    x_reg, x_next;
    logic [W-1:0]    r_reg, r_next;
    logic [W-1:0]    e_reg, e_next;
    logic [W-1:0]    lim_reg, lim_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   n_reg, n_next;
    logic            neg_reg, neg_next;
    logic [NP+1:0]   rem_reg, rem_next;
    logic [NP-1:0]   root_reg, root_next;
    logic [2*NP-1:0] sq_reg, sq_next;
    logic [W-1:0]    rv_reg, rv_next;
    status_t         rs_reg, rs_next;
    logic            ov_reg, ov_next;
    logic [W-1:0]    oval_reg, oval_next;
    status_t         ost_reg, ost_next;

    kind_t         kind_in;
    logic [W-1:0]  a_in, b_in, a_mag, b_mag;
    logic          a_neg, b_neg, odd, pneg;
    logic [W:0]    mul_sum;
    logic [W-1:0]  mul_hi, mul_lo;
    logic [W:0]    div_sh;
    logic          div_ge;
    logic [W:0]    div_sub;
    logic [W-1:0]  q_new;
    logic [NP+1:0] rt_sh, rt_trial;
    logic          rt_ge;
    logic [NP-1:0] root_new;

    assign kind_in = kind_t'(s_axis_tuser);
    assign a_in    = s_axis_tdata[W-1:0];
    assign b_in    = s_axis_tdata[2*W-1:W];
    assign a_neg   = a_in[W-1];
    assign b_neg   = b_in[W-1];
    assign a_mag   = a_neg ? (~a_in + ONE) : a_in;
    assign b_mag   = b_neg ? (~b_in + ONE) : b_in;
    assign odd     = b_in[0];
    assign pneg    = a_neg && odd;

    // shift-add multiply: one multiplier bit per cycle
    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, x_reg} : {(W+1){1'b0}});
    assign mul_hi  = mul_sum[W:1];
    assign mul_lo  = {mul_sum[0], lo_reg[W-1:1]};

    // restoring divide: one quotient bit per cycle
    assign div_sh  = {hi_reg, lo_reg[W-1]};
    assign div_ge  = div_sh >= {1'b0, x_reg};
    assign div_sub = div_sh - {1'b0, x_reg};
    assign q_new   = {lo_reg[W-2:0], div_ge};

    // digit-by-digit root: one root bit per cycle
    assign rt_sh    = {rem_reg[NP-1:0], sq_reg[2*NP-1 -: 2]};
    assign rt_trial = {root_reg, 2'b01};
    assign rt_ge    = rt_sh >= rt_trial;
    assign root_new = {root_reg[NP-2:0], rt_ge};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = OUT_W'({ost_reg, oval_reg});

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        e_next     = e_reg;
        lim_next   = lim_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        sq_next    = sq_reg;
        rv_next    = rv_reg;
        rs_next    = rs_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        ost_next   = ost_reg;

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = kind_in;
                    rs_next    = ST_OK;
                    rv_next    = '0;
                    cnt_next   = CW'(W);
                    state_next = S_FIN;
                    unique case (kind_in)
                        K_ADD: rv_next = a_in + b_in;
                        K_SUB: rv_next = a_in - b_in;
                        K_MUL:
                        begin
                            x_next     = a_in;
                            lo_next    = b_in;
                            hi_next    = '0;
                            state_next = S_MUL;
                        end
                        K_DIV:
                        begin
                            if (b_in == '0)
                            begin
                                rs_next = ST_DIVZERO;
                            end
                            else if (a_in == SIGN_BIT && b_in == '1)
                            begin
                                rs_next = ST_OVF;
                            end
                            else
                            begin
                                lo_next    = a_mag;
                                x_next     = b_mag;
                                hi_next    = '0;
                                neg_next   = a_neg ^ b_neg;
                                state_next = S_DIV;
                            end
                        end
                        K_PCT:
                        begin
                            lo_next    = a_mag;
                            x_next     = W'(PERCENT_DIV);
                            hi_next    = '0;
                            neg_next   = a_neg;
                            state_next = S_DIV;
                        end
                        K_SQRT:
                        begin
                            if (a_neg)
                            begin
                                rs_next = ST_NEGROOT;
                            end
                            else
                            begin
                                sq_next    = (2*NP)'(a_in);
                                rem_next   = '0;
                                root_next  = '0;
                                cnt_next   = CW'(NP);
                                state_next = S_ROOT;
                            end
                        end
                        K_POW:
                        begin
                            if (b_neg || b_in == '0 || a_mag == '0 || a_mag == ONE)
                            begin
                                if (b_neg && a_mag == '0)
                                begin
                                    rs_next = ST_OVF;
                                end
                                else if (a_mag == ONE)
                                begin
                                    rv_next = pneg ? '1 : ONE;
                                end
                                else if (b_neg)
                                begin
                                    rv_next = '0;
                                end
                                else if (b_in == '0)
                                begin
                                    rv_next = ONE;
                                end
                                else
                                begin
                                    rv_next = '0;
                                end
                            end
                            else
                            begin
                                x_next     = a_mag;
                                r_next     = ONE;
                                e_next     = b_in;
                                neg_next   = pneg;
                                lim_next   = pneg ? SIGN_BIT : (SIGN_BIT - ONE);
                                state_next = S_LOOP;
                            end
                        end
                        K_FACT:
                        begin
                            if (a_neg)
                            begin
                                rv_next = ONE;
                            end
                            else if (a_in >= W'(2 * W))
                            begin
                                rv_next = '0;
                            end
                            else
                            begin
                                r_next     = ONE;
                                i_next     = IW'(2);
                                n_next     = a_in[IW-1:0];
                                state_next = S_LOOP;
                            end
                        end
                    endcase
                end
            end

            S_LOOP:
            begin
                hi_next  = '0;
                lo_next  = r_reg;
                cnt_next = CW'(W);
                if (op_reg == K_POW)
                begin
                    if (e_reg == '0)
                    begin
                        rv_next    = neg_reg ? (~r_reg + ONE) : r_reg;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    if (i_reg > n_reg)
                    begin
                        rv_next    = r_reg;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        x_next     = W'(i_reg);
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                hi_next  = mul_hi;
                lo_next  = mul_lo;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (op_reg == K_MUL)
                    begin
                        rv_next    = mul_lo;
                        state_next = S_FIN;
                    end
                    else if (op_reg == K_POW)
                    begin
                        if (mul_hi != '0 || mul_lo > lim_reg)
                        begin
                            rs_next    = ST_OVF;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            r_next     = mul_lo;
                            e_next     = e_reg - ONE;
                            state_next = S_LOOP;
                        end
                    end
                    else
                    begin
                        r_next     = mul_lo;
                        i_next     = i_reg + IW'(1);
                        state_next = S_LOOP;
                    end
                end
            end

            S_DIV:
            begin
                hi_next  = div_ge ? div_sub[W-1:0] : div_sh[W-1:0];
                lo_next  = q_new;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    rv_next    = neg_reg ? (~q_new + ONE) : q_new;
                    state_next = S_FIN;
                end
            end

            S_ROOT:
            begin
                rem_next  = rt_ge ? (rt_sh - rt_trial) : rt_sh;
                root_next = root_new;
                sq_next   = {sq_reg[2*NP-3:0], 2'b00};
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    rv_next    = W'(root_new);
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                // hold until the output register is free
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    oval_next  = (rs_reg == ST_OK) ? rv_reg : '0;
                    ost_next   = rs_reg;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        e_reg    <= e_next;
        lim_reg  <= lim_next;
        i_reg    <= i_next;
        n_reg    <= n_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        sq_reg   <= sq_next;
        rv_reg   <= rv_next;
        rs_reg   <= rs_next;
        oval_reg <= oval_next;
        ost_reg  <= ost_next;
    end

endmodule

`default_nettype wire

[rtl/core/icalc_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module icalc_chk
    import icalc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input wire                                          clk,
    input wire                                          rst_n,
    input wire                                          s_axis_tvalid,
    input wire                                          s_axis_tready,
    input wire                                          m_axis_tvalid,
    input wire                                          m_axis_tready,
    // value, status, zero pad
    input wire  [((DATA_WIDTH + 2 + 7) / 8) * 8 - 1:0]   m_axis_tdata
);

    localparam int W = DATA_WIDTH;

    // an error status always carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[W+1:W] != ST_OK) |-> (m_axis_tdata[W-1:0] == '0))
        else $error("error status with nonzero value");

    // one word in flight: input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while busy");

    // a word reaches the output only after an input was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid ##1 m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("output without work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

endmodule

bind integer_calculator_alu icalc_chk #(.DATA_WIDTH(DATA_WIDTH)) u_icalc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
